>>> design/mqbm_pkg.sv
// ----------------------------------------------------------------------------
// mqbm_pkg
// Shared types and constants of the multi-queue buffer manager.
// ----------------------------------------------------------------------------
package mqbm_pkg;

   localparam int MODE_W   = 3;
   localparam int QIDX_W   = 4;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int CNT_W    = 5;
   localparam int LEN_W    = 11;

   localparam int REQ_BITS  = MODE_W + QIDX_W + VALUE_W;
   localparam int REQ_W     = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS  = VALUE_W + STATUS_W + CNT_W + LEN_W;
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ENQ    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DEQ    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STAT   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD,
      S_LOOKUP,
      S_EXEC,
      S_ENQ_LINK,
      S_DEQ_DATA,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_REM_NODES,
      S_WALK_RD,
      S_WALK_WR,
      S_LEN_RD,
      S_LEN_WAIT,
      S_DONE
   } state_type;

endpackage

>>> design/mqbm_ram.sv
// ----------------------------------------------------------------------------
// mqbm_ram
// Simple dual-port RAM with bit write mask and registered read.
// ----------------------------------------------------------------------------
module mqbm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [WIDTH-1:0]         wr_mask,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= (mem[wr_addr] & ~wr_mask) | (wr_data & wr_mask);
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> design/multi_queue_buffer_manager.sv
// ----------------------------------------------------------------------------
// multi_queue_buffer_manager
// Variable set of FIFO queues kept as linked lists in one shared node memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command transaction: mode (add queue, remove queue,
//   enqueue, dequeue, status read), queue index and an enqueue value.
//   rsp_* returns exactly one result transaction per command: dequeued value,
//   status code, queue count and the size of the addressed queue.
//   Commands are worked one at a time. A queue table memory (head, tail,
//   size) and a node memory (value, next) both have a registered read.
//   An enqueue onto a non-empty queue also links the new node behind the
//   old tail. A remove first shifts the queues above the removed one down
//   one slot, then hands the removed nodes round the remaining queues in
//   turn, or splices them onto the free list when no queue is left, and
//   then reads the size of the queue now at the index, if there is one.
//   The shift and relink walks are set by the single read port of the queue
//   table: each entry is read and then written back.
//   A new command is taken while an earlier result still sits in the output
//   register; a stalled receiver holds the result and the block waits in its
//   final state until the register frees up.
//   Reset clears the queue count, the free list and the fresh-node mark;
//   memories need no clearing, since only written entries are ever read.
// ----------------------------------------------------------------------------
module multi_queue_buffer_manager #(
   parameter int MAX_QUEUES = 16,
   parameter int NODE_DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // mode[2:0], queue_index[6:3], data_value[38:7], zero pad
   input  logic [mqbm_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // out_value[31:0], status[34:32], queue_count[39:35], queue_length[50:40]
   output logic [mqbm_pkg::RSP_W-1:0] rsp_tdata
);

   import mqbm_pkg::*;

   localparam int QW   = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
   localparam int CW   = $clog2(MAX_QUEUES + 1);
   localparam int NW   = $clog2(NODE_DEPTH);
   localparam int SW   = NW + 1;
   localparam int CMPW = (CW > QIDX_W) ? CW : QIDX_W;
   localparam int QTW  = 2 * NW + SW;      // {head, tail, size}
   localparam int NDW  = VALUE_W + NW;     // {value, next}

   localparam logic [NDW-1:0] NEXT_MASK  = {{VALUE_W{1'b0}}, {NW{1'b1}}};
   localparam logic [NDW-1:0] VALUE_MASK = {{VALUE_W{1'b1}}, {NW{1'b0}}};

   // control and bookkeeping registers
   state_type          state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [QIDX_W-1:0]  qidx_ff, qidx_in;
   logic [VALUE_W-1:0] data_ff, data_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [NW-1:0]      free_head_ff, free_head_in;
   logic [SW-1:0]      free_count_ff, free_count_in;
   logic [SW-1:0]      fresh_ff, fresh_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [SW-1:0]      len_ff, len_in;
   logic [NW-1:0]      cur_ff, cur_in;
   logic [NW-1:0]      last_ff, last_in;
   logic [SW-1:0]      rlen_ff, rlen_in;
   logic [QW-1:0]      idx_ff, idx_in;

   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;

   // memory ports
   logic               qt_we, nd_we;
   logic [QW-1:0]      qt_waddr, qt_raddr;
   logic [QTW-1:0]     qt_wdata, qt_rdata;
   logic [NW-1:0]      nd_waddr, nd_raddr;
   logic [NDW-1:0]     nd_wdata, nd_wmask, nd_rdata;

   // decoded read data
   logic [NW-1:0]      rd_head, rd_tail, rd_next;
   logic [SW-1:0]      rd_size;
   logic [VALUE_W-1:0] rd_value;

   logic               req_take, rsp_load, q_valid;
   logic [QW-1:0]      qa;
   logic [CW-1:0]      idx_plus;

   assign {rd_head, rd_tail, rd_size} = qt_rdata;
   assign {rd_value, rd_next}         = nd_rdata;

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign qa         = QW'(qidx_ff);
   assign q_valid    = CMPW'(qidx_ff) < CMPW'(count_ff);
   assign idx_plus   = CW'(idx_ff) + CW'(1);

   mqbm_ram #(.WIDTH(QTW), .DEPTH(MAX_QUEUES)) u_qtab (
      .clock   (clock),
      .wr_en   (qt_we),
      .wr_addr (qt_waddr),
      .wr_data (qt_wdata),
      .wr_mask ({QTW{1'b1}}),
      .rd_addr (qt_raddr),
      .rd_data (qt_rdata)
   );

   mqbm_ram #(.WIDTH(NDW), .DEPTH(NODE_DEPTH)) u_nodes (
      .clock   (clock),
      .wr_en   (nd_we),
      .wr_addr (nd_waddr),
      .wr_data (nd_wdata),
      .wr_mask (nd_wmask),
      .rd_addr (nd_raddr),
      .rd_data (nd_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = (MODE_W'(req_tdata[MODE_W-1:0]) == MODE_ADD) ? S_ADD : S_LOOKUP;
            end
         end
         S_ADD:      state_in = S_DONE;
         S_LOOKUP:   state_in = q_valid ? S_EXEC : S_DONE;
         S_EXEC: begin
            case (mode_ff)
               MODE_ENQ: begin
                  if ((free_count_ff != '0 || fresh_ff < SW'(NODE_DEPTH)) && rd_size != '0) begin
                     state_in = S_ENQ_LINK;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               MODE_DEQ:    state_in = (rd_size == '0) ? S_DONE : S_DEQ_DATA;
               MODE_REMOVE: state_in = S_SHIFT_RD;
               default:     state_in = S_DONE;
            endcase
         end
         S_ENQ_LINK:  state_in = S_DONE;
         S_DEQ_DATA:  state_in = S_DONE;
         S_SHIFT_RD:  state_in = (idx_plus < count_ff) ? S_SHIFT_WR : S_REM_NODES;
         S_SHIFT_WR:  state_in = S_SHIFT_RD;
         S_REM_NODES: begin
            if (rlen_ff == '0 || count_ff == '0) begin
               state_in = S_LEN_RD;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_WALK_RD:   state_in = S_WALK_WR;
         S_WALK_WR:   state_in = (rlen_ff == SW'(1)) ? S_LEN_RD : S_WALK_RD;
         S_LEN_RD:    state_in = q_valid ? S_LEN_WAIT : S_DONE;
         S_LEN_WAIT:  state_in = S_DONE;
         S_DONE:      state_in = rsp_load ? S_IDLE : S_DONE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and memory ports
   always_comb begin
      mode_in       = mode_ff;
      qidx_in       = qidx_ff;
      data_in       = data_ff;
      count_in      = count_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      fresh_in      = fresh_ff;
      status_in     = status_ff;
      value_in      = value_ff;
      len_in        = len_ff;
      cur_in        = cur_ff;
      last_in       = last_ff;
      rlen_in       = rlen_ff;
      idx_in        = idx_ff;
      qt_we         = 1'b0;
      qt_waddr      = qa;
      qt_wdata      = '0;
      qt_raddr      = qa;
      nd_we         = 1'b0;
      nd_waddr      = cur_ff;
      nd_wdata      = '0;
      nd_wmask      = NEXT_MASK;
      nd_raddr      = free_head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               mode_in   = req_tdata[MODE_W-1:0];
               qidx_in   = req_tdata[MODE_W +: QIDX_W];
               data_in   = req_tdata[MODE_W+QIDX_W +: VALUE_W];
               status_in = ST_OK;
               value_in  = '0;
               len_in    = '0;
            end
         end
         S_ADD: begin
            if (count_ff >= CW'(MAX_QUEUES)) begin
               status_in = ST_NO_SLOT;
            end else begin
               // open an empty queue at the end of the table
               qt_we    = 1'b1;
               qt_waddr = QW'(count_ff);
               qt_wdata = '0;
               count_in = count_ff + CW'(1);
            end
         end
         S_LOOKUP: begin
            // read addressed queue and the free-list head together
            qt_raddr = qa;
            nd_raddr = free_head_ff;
            if (!q_valid) begin
               status_in = ST_BAD_INDEX;
            end
         end
         S_EXEC: begin
            case (mode_ff)
               MODE_ENQ: begin
                  len_in  = rd_size;
                  last_in = rd_tail;
                  if (free_count_ff != '0) begin
                     cur_in        = free_head_ff;
                     free_head_in  = rd_next;
                     free_count_in = free_count_ff - SW'(1);
                  end else if (fresh_ff < SW'(NODE_DEPTH)) begin
                     cur_in   = NW'(fresh_ff);
                     fresh_in = fresh_ff + SW'(1);
                  end else begin
                     status_in = ST_FULL;
                  end
                  if (free_count_ff != '0 || fresh_ff < SW'(NODE_DEPTH)) begin
                     nd_we    = 1'b1;
                     nd_waddr = cur_in;
                     nd_wdata = {data_ff, {NW{1'b0}}};
                     nd_wmask = VALUE_MASK;
                     qt_we    = 1'b1;
                     qt_waddr = qa;
                     qt_wdata = {(rd_size == '0) ? cur_in : rd_head, cur_in,
                                 rd_size + SW'(1)};
                     len_in   = rd_size + SW'(1);
                  end
               end
               MODE_DEQ: begin
                  if (rd_size == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     nd_raddr = rd_head;
                     cur_in   = rd_head;
                     last_in  = rd_tail;
                     rlen_in  = rd_size;
                  end
               end
               MODE_REMOVE: begin
                  cur_in  = rd_head;
                  last_in = rd_tail;
                  rlen_in = rd_size;
                  idx_in  = qa;
               end
               default: begin
                  len_in = rd_size;
               end
            endcase
         end
         S_ENQ_LINK: begin
            // hook the new node behind the old tail
            nd_we    = 1'b1;
            nd_waddr = last_ff;
            nd_wdata = {{VALUE_W{1'b0}}, cur_ff};
            nd_wmask = NEXT_MASK;
         end
         S_DEQ_DATA: begin
            value_in      = rd_value;
            qt_we         = 1'b1;
            qt_waddr      = qa;
            qt_wdata      = {rd_next, last_ff, rlen_ff - SW'(1)};
            len_in        = rlen_ff - SW'(1);
            // push the freed node onto the free list
            nd_we         = 1'b1;
            nd_waddr      = cur_ff;
            nd_wdata      = {{VALUE_W{1'b0}}, free_head_ff};
            nd_wmask      = NEXT_MASK;
            free_head_in  = cur_ff;
            free_count_in = free_count_ff + SW'(1);
         end
         S_SHIFT_RD: begin
            qt_raddr = QW'(idx_plus);
            if (!(idx_plus < count_ff)) begin
               count_in = count_ff - CW'(1);
            end
         end
         S_SHIFT_WR: begin
            // move the higher entry down one slot
            qt_we    = 1'b1;
            qt_waddr = idx_ff;
            qt_wdata = qt_rdata;
            idx_in   = QW'(idx_plus);
         end
         S_REM_NODES: begin
            idx_in = '0;
            if (rlen_ff != '0 && count_ff == '0) begin
               // no queue left: splice the whole chain onto the free list
               nd_we         = 1'b1;
               nd_waddr      = last_ff;
               nd_wdata      = {{VALUE_W{1'b0}}, free_head_ff};
               nd_wmask      = NEXT_MASK;
               free_head_in  = cur_ff;
               free_count_in = free_count_ff + rlen_ff;
            end
         end
         S_WALK_RD: begin
            nd_raddr = cur_ff;
            qt_raddr = idx_ff;
         end
         S_WALK_WR: begin
            qt_we    = 1'b1;
            qt_waddr = idx_ff;
            qt_wdata = {(rd_size == '0) ? cur_ff : rd_head, cur_ff, rd_size + SW'(1)};
            if (rd_size != '0) begin
               nd_we    = 1'b1;
               nd_waddr = rd_tail;
               nd_wdata = {{VALUE_W{1'b0}}, cur_ff};
               nd_wmask = NEXT_MASK;
            end
            cur_in  = rd_next;
            rlen_in = rlen_ff - SW'(1);
            idx_in  = (idx_plus == count_ff) ? '0 : QW'(idx_plus);
         end
         S_LEN_RD: begin
            qt_raddr = qa;
            len_in   = '0;
         end
         S_LEN_WAIT: begin
            len_in = rd_size;
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         free_head_ff  <= '0;
         free_count_ff <= '0;
         fresh_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         fresh_ff      <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      qidx_ff   <= qidx_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      len_ff    <= len_in;
      cur_ff    <= cur_in;
      last_ff   <= last_in;
      rlen_ff   <= rlen_in;
      idx_ff    <= idx_in;
   end

   // output register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= RSP_W'({LEN_W'(len_ff), CNT_W'(count_ff), status_ff, value_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> design/mqbm_checker.sv
// ----------------------------------------------------------------------------
// mqbm_checker
// Port-level checks of the multi-queue buffer manager result stream.
// ----------------------------------------------------------------------------
module mqbm_checker #(
   parameter int MAX_QUEUES = 16
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [mqbm_pkg::RSP_W-1:0] rsp_tdata
);

   import mqbm_pkg::*;

   logic [VALUE_W-1:0]  c_value;
   logic [STATUS_W-1:0] c_status;
   logic [CNT_W-1:0]    c_count;
   logic [LEN_W-1:0]    c_len;

   assign c_value  = rsp_tdata[0 +: VALUE_W];
   assign c_status = rsp_tdata[VALUE_W +: STATUS_W];
   assign c_count  = rsp_tdata[VALUE_W+STATUS_W +: CNT_W];
   assign c_len    = rsp_tdata[VALUE_W+STATUS_W+CNT_W +: LEN_W];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (c_status <= ST_FULL))
      else $error("status code out of range");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(c_count) <= 32'(MAX_QUEUES)))
      else $error("queue count above table size");

   a_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && c_status != ST_OK |-> c_value == '0)
      else $error("value on a failed command");

   a_badlen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (c_status == ST_BAD_INDEX || c_status == ST_NO_SLOT) |-> c_len == '0)
      else $error("length on a missing queue");

endmodule

bind multi_queue_buffer_manager mqbm_checker #(.MAX_QUEUES(MAX_QUEUES)) u_mqbm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
